// ----- rtl/core/alm_pkg.sv -----
// ---------------------------------------------------------------------------
// alm_pkg: shared types and constants of the audio level meter
// Widths, register indexes, controller states and the memory request bundle.
// ---------------------------------------------------------------------------
package alm_pkg;

	localparam int MAX_CHANNELS = 8;
	localparam int CH_W         = 3;
	localparam int CNT_W        = 4;
	localparam int FRM_W        = 16;
	localparam int SAMPLE_W     = 16;
	localparam int MAG_W        = SAMPLE_W + 1;
	localparam int SUM_W        = 32;
	localparam int LEVEL_W      = 7;
	localparam int SCALE_W      = 9;
	localparam int NUM_W        = SUM_W + SCALE_W;
	localparam int FULL_SHIFT   = 15;              // full scale is 2^15 - 1
	localparam int DEN_W        = FRM_W + FULL_SHIFT;
	localparam int QUO_W        = 9;               // quotient stays below 512
	localparam int DSR_W        = DEN_W + QUO_W - 1;
	localparam int STEP_W       = 4;
	localparam int CFG_IDX_W    = 1;
	localparam int CFG_DATA_W   = 16;

	localparam logic [SCALE_W-1:0] LEVEL_SCALE   = 9'd500;
	localparam logic [LEVEL_W-1:0] LEVEL_CAP     = 7'd100;
	localparam logic [CNT_W-1:0]   CNT_RESET     = 4'd2;
	localparam logic [FRM_W-1:0]   FRM_RESET     = 16'd2400;
	localparam logic [CNT_W-1:0]   CNT_MAX       = CNT_W'(MAX_CHANNELS);

	typedef logic [CH_W-1:0] chan_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CHANNEL_COUNT = 1'b0,
		REG_FRAMES        = 1'b1
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ACC,
		ST_RD,
		ST_MUL,
		ST_DIV,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic              rd_en;
		chan_t             rd_addr;
		logic              wr_en;
		chan_t             wr_addr;
		logic [SUM_W-1:0]  wr_data;
		logic              clr;
	} mem_req_t;

endpackage

// ----- rtl/core/alm_if.sv -----
// ---------------------------------------------------------------------------
// alm_if: stream interfaces of the audio level meter
// Sample stream in, level stream out, each with valid/ready.
// ---------------------------------------------------------------------------
interface alm_sample_if;
	import alm_pkg::*;

	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] sample;

	modport source(output valid, output sample, input ready);
	modport sink(input valid, input sample, output ready);
endinterface

interface alm_level_if;
	import alm_pkg::*;

	logic               valid;
	logic               ready;
	logic [CH_W-1:0]    channel;
	logic [LEVEL_W-1:0] level;
	logic               last;

	modport source(output valid, output channel, output level, output last, input ready);
	modport sink(input valid, input channel, input level, input last, output ready);
endinterface

// ----- rtl/core/alm_sum_mem.sv -----
// ---------------------------------------------------------------------------
// alm_sum_mem: per-channel magnitude sums
// Synchronous memory with registered read data; a valid bit per entry
// makes an unwritten or cleared entry read as zero.
// ---------------------------------------------------------------------------
module alm_sum_mem (
	input  logic                   clk,
	input  logic                   arst_n,
	input  alm_pkg::mem_req_t      req,
	output logic [alm_pkg::SUM_W-1:0] rd_data
);
	import alm_pkg::*;

	logic [SUM_W-1:0]        sum_mem [MAX_CHANNELS];
	logic [MAX_CHANNELS-1:0] vld_q;
	logic [SUM_W-1:0]        rdata_q;
	logic                    rvld_q;

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			sum_mem[req.wr_addr] <= req.wr_data;
		end
		if (req.rd_en) begin
			rdata_q <= sum_mem[req.rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			rvld_q <= 1'b0;
		end else begin
			if (req.clr) begin
				vld_q <= '0;
			end else if (req.wr_en) begin
				vld_q[req.wr_addr] <= 1'b1;
			end
			if (req.rd_en) begin
				rvld_q <= vld_q[req.rd_addr];
			end
		end
	end

	assign rd_data = rvld_q ? rdata_q : '0;

endmodule

// ----- rtl/core/alm_div.sv -----
// ---------------------------------------------------------------------------
// alm_div: level divider
// Restoring division, one quotient bit per cycle, MSB first; the quotient
// is clamped to the level cap.
// ---------------------------------------------------------------------------
module alm_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [alm_pkg::NUM_W-1:0]   num,
	input  logic [alm_pkg::DEN_W-1:0]   den,
	output logic                        done,
	output logic [alm_pkg::LEVEL_W-1:0] level
);
	import alm_pkg::*;

	logic [NUM_W-1:0]  rem_q;
	logic [DSR_W-1:0]  dsr_q;
	logic [QUO_W-1:0]  quo_q;
	logic [STEP_W-1:0] step_q;
	logic              busy_q;
	logic              done_q;
	logic              ge;

	assign ge = NUM_W'(dsr_q) <= rem_q;

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num;
			dsr_q <= {den, {(QUO_W-1){1'b0}}};
			quo_q <= '0;
		end else if (busy_q) begin
			if (ge) begin
				rem_q <= rem_q - NUM_W'(dsr_q);
			end
			quo_q <= {quo_q[QUO_W-2:0], ge};
			dsr_q <= dsr_q >> 1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + STEP_W'(1);
				if (step_q == STEP_W'(QUO_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done  = done_q;
	assign level = (quo_q > QUO_W'(LEVEL_CAP)) ? LEVEL_CAP : quo_q[LEVEL_W-1:0];

endmodule

// ----- rtl/core/multichannel_audio_level_meter_unit.sv -----
// ---------------------------------------------------------------------------
// multichannel_audio_level_meter_unit: mean absolute level meter
// Sums sample magnitudes per channel and reports one level per channel at
// the end of every period.
// ---------------------------------------------------------------------------
// Samples arrive interleaved, channel 0 first. For each sample, the
// channel's sum is read from the sum memory and written back with the
// magnitude added. After the last sample of a period the block emits one
// level per channel in channel order, last flag on the final one; each level
// passes through a memory read, a multiply by 500, a nine-step divider and
// an output load that waits while the level sink stalls. No sample is taken
// during emission. level = min(100, floor(sum * 500 / (frames * 32767))).
// A configuration write starts a new period and discards partial sums.
module multichannel_audio_level_meter_unit (
	input  logic                             clk,
	input  logic                             arst_n,
	alm_sample_if.sink                       samples,
	alm_level_if.source                      levels,
	input  logic                             wr_en,
	input  logic [alm_pkg::CFG_IDX_W-1:0]    wr_index,
	input  logic [alm_pkg::CFG_DATA_W-1:0]   wr_data
);
	import alm_pkg::*;

	state_t             state_q, state_nx;
	logic [CNT_W-1:0]   cnt_q;
	logic [FRM_W-1:0]   frm_q;
	chan_t              ci_q;
	chan_t              oc_q;
	logic [FRM_W-1:0]   fc_q;
	logic [MAG_W-1:0]   mag_q;
	logic [DEN_W-1:0]   den_q;
	logic               ov_q;
	chan_t              och_q;
	logic [LEVEL_W-1:0] olvl_q;
	logic               olast_q;

	logic [CNT_W-1:0]   chans;
	logic [FRM_W-1:0]   frames;
	chan_t              ci_eff;
	logic               ci_last;
	logic               oc_last;
	logic [FRM_W-1:0]   fc_next;
	logic               period_end;
	logic               out_free;
	logic [MAG_W-1:0]   mag;
	mem_req_t           mem_req;
	logic [SUM_W-1:0]   mem_rdata;
	logic [NUM_W-1:0]   prod;
	logic               div_start;
	logic               div_done;
	logic [LEVEL_W-1:0] div_level;
	logic               load_out;
	logic               emit_end;

	// Active channel count and period length after saturation
	assign chans  = (cnt_q == '0) ? CNT_W'(1) : ((cnt_q > CNT_MAX) ? CNT_MAX : cnt_q);
	assign frames = (frm_q == '0) ? FRM_W'(1) : frm_q;

	assign ci_eff     = ({1'b0, ci_q} >= chans) ? CH_W'(chans - CNT_W'(1)) : ci_q;
	assign ci_last    = ({1'b0, ci_eff} + CNT_W'(1)) == chans;
	assign oc_last    = ({1'b0, oc_q} + CNT_W'(1)) == chans;
	assign fc_next    = fc_q + FRM_W'(1);
	assign period_end = ci_last && (fc_next >= frames);
	assign out_free   = !ov_q || levels.ready;

	assign mag = samples.sample[SAMPLE_W-1]
		? MAG_W'(MAG_W'(1 << SAMPLE_W) - MAG_W'(samples.sample[SAMPLE_W-1:0]))
		: MAG_W'(samples.sample[SAMPLE_W-1:0]);

	assign prod = NUM_W'(mem_rdata) * NUM_W'(LEVEL_SCALE);

	alm_sum_mem u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (mem_req),
		.rd_data (mem_rdata)
	);

	alm_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (prod),
		.den    (den_q),
		.done   (div_done),
		.level  (div_level)
	);

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE: if (samples.valid) state_nx = ST_ACC;
			ST_ACC:  state_nx = period_end ? ST_RD : ST_IDLE;
			ST_RD:   state_nx = ST_MUL;
			ST_MUL:  state_nx = ST_DIV;
			ST_DIV:  if (div_done) state_nx = ST_OUT;
			ST_OUT: begin
				if (out_free) begin
					state_nx = oc_last ? ST_IDLE : ST_RD;
				end
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	always_comb begin
		samples.ready   = 1'b0;
		mem_req.rd_en   = 1'b0;
		mem_req.rd_addr = oc_q;
		mem_req.wr_en   = 1'b0;
		mem_req.wr_addr = ci_eff;
		mem_req.wr_data = mem_rdata + SUM_W'(mag_q);
		div_start       = 1'b0;
		load_out        = 1'b0;
		emit_end        = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				samples.ready   = 1'b1;
				mem_req.rd_en   = samples.valid;
				mem_req.rd_addr = ci_eff;
			end
			ST_ACC:  mem_req.wr_en = 1'b1;
			ST_RD:   mem_req.rd_en = 1'b1;
			ST_MUL:  div_start = 1'b1;
			ST_DIV:  ;
			ST_OUT: begin
				load_out = out_free;
				emit_end = out_free && oc_last;
			end
			default: ;
		endcase
		mem_req.clr = wr_en || emit_end;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= CNT_RESET;
			frm_q   <= FRM_RESET;
			ci_q    <= '0;
			oc_q    <= '0;
			fc_q    <= '0;
			ov_q    <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (wr_en) begin
				case (cfg_reg_t'(wr_index))
					REG_CHANNEL_COUNT: cnt_q <= wr_data[CNT_W-1:0];
					REG_FRAMES:        frm_q <= wr_data[FRM_W-1:0];
					default:           ;
				endcase
				ci_q <= '0;
				fc_q <= '0;
			end else if (state_q == ST_ACC) begin
				ci_q <= ci_last ? '0 : ci_eff + CH_W'(1);
				if (ci_last) begin
					fc_q <= fc_next;
				end
				oc_q <= '0;
			end else if (load_out) begin
				oc_q <= oc_last ? '0 : oc_q + CH_W'(1);
				if (oc_last) begin
					fc_q <= '0;
				end
			end
			if (load_out) begin
				ov_q <= 1'b1;
			end else if (levels.ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (samples.valid && samples.ready) begin
			mag_q <= mag;
		end
		if (state_q == ST_RD) begin
			den_q <= (DEN_W'(frames) << FULL_SHIFT) - DEN_W'(frames);
		end
		if (load_out) begin
			och_q   <= oc_q;
			olvl_q  <= div_level;
			olast_q <= oc_last;
		end
	end

	assign levels.valid   = ov_q;
	assign levels.channel = och_q;
	assign levels.level   = olvl_q;
	assign levels.last    = olast_q;

	a_level_cap: assert property (@(posedge clk) disable iff (!arst_n)
		levels.valid |-> levels.level <= LEVEL_CAP)
		else $error("level above cap");

	a_last_chan: assert property (@(posedge clk) disable iff (!arst_n)
		(levels.valid && levels.last) |-> ({1'b0, levels.channel} + CNT_W'(1)) == chans)
		else $error("last flag on wrong channel");

	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == ST_DIV)
		else $error("divider finished outside divide state");

endmodule
